// ===== rtl/ptd_pkg.sv =====
// Shared constants and types for the periodic tick task dispatcher.
package ptd_pkg;

  // Number of task slots in the table.
  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Fixed field widths.
  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 3;
  localparam int PERIOD_W = 16;
  localparam int CNT_W    = $clog2(PERIOD_W);

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_RESUME  = 3'd4
  } cmd_t;

  // One slot table entry as held in the memory.
  typedef struct packed {
    logic                present;
    logic                active;
    logic [PERIOD_W-1:0] period;
  } slot_entry_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_EDIT = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

endpackage

// ===== rtl/periodic_tick_task_dispatcher_unit.sv =====
// Periodic tick task dispatcher: slot table memory, slot walker and serial remainder unit.
//
// A request is taken when start is high and busy is low. Create, delete, suspend and
// resume read the slot entry from the table memory and write it back modified; they
// give no result. A tick walks every slot in turn: each slot costs a memory read and a
// check, and each present, active slot with a nonzero period a 16-step restoring
// remainder of the tick count by its period, one bit per cycle. Each result is shown
// for exactly one cycle with out_valid high and cannot be held off; the final result
// of a tick carries out_last. Each due slot is held back until the walker knows
// whether it is the last, so the final two results of a tick can come on consecutive
// cycles.
module periodic_tick_task_dispatcher_unit import ptd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [PERIOD_W-1:0] in_period,
  output logic                out_valid,
  output logic [SLOT_W-1:0]   out_task_index,
  output logic                out_due,
  output logic                out_last
);

  // Table memory, its per-entry valid bits and the read port.
  slot_entry_t          mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] mem_vld_r;
  slot_entry_t          rd_q_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_addr;
  slot_entry_t          rd_entry;
  logic                 mem_we;
  slot_entry_t          mem_wdata;

  // Sequencer and request registers.
  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [PERIOD_W-1:0]  period_r, period_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [PERIOD_W-1:0]  tick_r, tick_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;

  // Remainder unit.
  logic [PERIOD_W-1:0]  rem_r, rem_nxt;
  logic [PERIOD_W-1:0]  dvd_r, dvd_nxt;
  logic [PERIOD_W-1:0]  div_per_r, div_per_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PERIOD_W:0]    trial;
  logic                 trial_ge;
  logic [PERIOD_W-1:0]  rem_step;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]    out_idx_r, out_idx_nxt;
  logic                 out_due_r, out_due_nxt;
  logic                 out_last_r, out_last_nxt;

  // Walker step helpers.
  logic                 accept;
  logic                 in_range;
  logic [IDX_W-1:0]     in_idx;
  logic                 step;
  logic                 hit;
  logic                 last_slot;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign in_idx    = IDX_W'(in_slot);
  assign in_range  = (32'(in_slot) < NUM_SLOTS);
  assign last_slot = (idx_r == IDX_W'(NUM_SLOTS - 1));

  // The read address is the addressed slot when idle, else the walker index.
  assign rd_addr  = (state_r == S_IDLE) ? in_idx : idx_r;
  // An entry never written reads as its reset value of zero.
  assign rd_entry = rd_vld_r ? rd_q_r : '0;

  // One restoring step of tick_count modulo period.
  assign trial    = {rem_r, dvd_r[PERIOD_W-1]};
  assign trial_ge = (trial >= {1'b0, div_per_r});
  assign rem_step = trial_ge ? PERIOD_W'(trial - {1'b0, div_per_r}) : trial[PERIOD_W-1:0];

  // Modified entry for the edit commands.
  always_comb begin
    mem_wdata = rd_entry;
    mem_we    = (state_r == S_EDIT);
    unique case (cmd_r)
      CMD_CREATE: begin
        mem_wdata.present = 1'b1;
        mem_wdata.active  = 1'b1;
        mem_wdata.period  = period_r;
      end
      CMD_DELETE:  mem_wdata.present = 1'b0;
      CMD_SUSPEND: mem_wdata.active  = 1'b0;
      CMD_RESUME:  mem_wdata.active  = 1'b1;
      default:     mem_we = 1'b0;
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= mem_wdata;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Valid bits stand in for clearing the table at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        mem_vld_r[slot_r] <= 1'b1;
      end
      rd_vld_r <= mem_vld_r[rd_addr];
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    slot_nxt      = slot_r;
    period_nxt    = period_r;
    idx_nxt       = idx_r;
    tick_nxt      = tick_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    div_per_nxt   = div_per_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_due_nxt   = out_due_r;
    out_last_nxt  = out_last_r;
    step          = 1'b0;
    hit           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_command;
          slot_nxt   = in_idx;
          period_nxt = in_period;
          priority if (in_command == CMD_TICK) begin
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_RD;
          end else if (in_range && (in_command == CMD_CREATE || in_command == CMD_DELETE ||
                       in_command == CMD_SUSPEND || in_command == CMD_RESUME)) begin
            state_nxt = S_EDIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (rd_entry.present && rd_entry.active && (rd_entry.period != '0)) begin
          rem_nxt     = '0;
          dvd_nxt     = tick_r;
          div_per_nxt = rd_entry.period;
          cnt_nxt     = '0;
          state_nxt   = S_DIV;
        end else begin
          step = 1'b1;
        end
      end
      S_DIV: begin
        rem_nxt = rem_step;
        dvd_nxt = {dvd_r[PERIOD_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PERIOD_W - 1)) begin
          step = 1'b1;
          hit  = (rem_step == '0);
        end
      end
      S_EDIT: begin
        state_nxt = S_IDLE;
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = pend_r ? SLOT_W'(pend_idx_r) : '0;
        out_due_nxt   = pend_r;
        out_last_nxt  = 1'b1;
        tick_nxt      = tick_r + 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A due slot is held until the next one shows it was not the last.
    if (step) begin
      if (hit) begin
        if (pend_r) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = SLOT_W'(pend_idx_r);
          out_due_nxt   = 1'b1;
          out_last_nxt  = 1'b0;
        end
        pend_nxt     = 1'b1;
        pend_idx_nxt = idx_r;
      end
      if (last_slot) begin
        state_nxt = S_FIN;
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_RD;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= PERIOD_W'(1);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    slot_r     <= slot_nxt;
    period_r   <= period_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    div_per_r  <= div_per_nxt;
    cnt_r      <= cnt_nxt;
    out_idx_r  <= out_idx_nxt;
    out_due_r  <= out_due_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_task_index = out_idx_r;
  assign out_due        = out_due_r;
  assign out_last       = out_last_r;

endmodule
